// ----- sv/lmsd_pkg.sv -----
// shared types and constants for the multiplexed lcd scan driver
`timescale 1ns / 1ps
package lmsd_pkg;

  localparam int NUM_COMMONS  = 4;
  localparam int NUM_SEGMENTS = 12;
  localparam int ROW_W        = $clog2(NUM_COMMONS);
  localparam int MODE_W       = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_UPDATE = 2'd0,
    MODE_BLANK  = 2'd1,
    MODE_SCAN   = 2'd2
  } mode_t;

  typedef logic [NUM_SEGMENTS-1:0] seg_word_t;
  typedef logic [NUM_COMMONS-1:0]  com_word_t;
  typedef logic [ROW_W-1:0]        row_t;

  // pin levels carried with one result transaction
  typedef struct packed {
    seg_word_t seg;
    com_word_t com_level;
    com_word_t com_enable;
  } pins_t;

  localparam pins_t PINS_RESET = '{seg: '0, com_level: '0, com_enable: '0};

endpackage

// ----- sv/lmsd_core.sv -----
// frame store, scan sequencer and pin state registers
`timescale 1ns / 1ps
module lmsd_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic [lmsd_pkg::MODE_W-1:0]      mode,
  input  lmsd_pkg::row_t                   row,
  input  lmsd_pkg::seg_word_t              set_bits,
  input  lmsd_pkg::seg_word_t              clear_bits,
  output lmsd_pkg::pins_t                  pins_next
);

  lmsd_pkg::seg_word_t frame_words [lmsd_pkg::NUM_COMMONS];
  lmsd_pkg::row_t      scan_row;
  logic                scan_phase;
  lmsd_pkg::pins_t     pins;

  lmsd_pkg::row_t      scan_row_next;
  logic                scan_phase_next;
  lmsd_pkg::seg_word_t cur_word;
  lmsd_pkg::com_word_t sel_bit;

  assign cur_word = frame_words[scan_row];
  assign sel_bit  = lmsd_pkg::com_word_t'(1) << scan_row;

  // next pin levels and scan position for this transaction
  always_comb begin
    pins_next       = pins;
    scan_row_next   = scan_row;
    scan_phase_next = scan_phase;
    case (mode)
      lmsd_pkg::MODE_BLANK: begin
        pins_next.seg        = '0;
        pins_next.com_level  = '0;
        pins_next.com_enable = '1;
      end
      lmsd_pkg::MODE_SCAN: begin
        pins_next.com_enable = sel_bit;
        if (!scan_phase) begin
          pins_next.seg       = cur_word;
          pins_next.com_level = pins.com_level & ~sel_bit;
          scan_phase_next     = 1'b1;
        end else begin
          pins_next.seg       = ~cur_word;
          pins_next.com_level = pins.com_level | sel_bit;
          scan_phase_next     = 1'b0;
          if (scan_row == lmsd_pkg::row_t'(lmsd_pkg::NUM_COMMONS - 1)) begin
            scan_row_next = '0;
          end else begin
            scan_row_next = scan_row + lmsd_pkg::row_t'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // control and pin state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row   <= '0;
      scan_phase <= 1'b0;
      pins       <= lmsd_pkg::PINS_RESET;
    end else if (accept) begin
      scan_row   <= scan_row_next;
      scan_phase <= scan_phase_next;
      pins       <= pins_next;
    end
  end

  // frame store, cleared at reset since its contents are shown on a scan
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lmsd_pkg::NUM_COMMONS; i++) begin
        frame_words[i] <= '0;
      end
    end else if (accept && mode == lmsd_pkg::MODE_UPDATE) begin
      frame_words[row] <= (frame_words[row] & ~clear_bits) | set_bits;
    end
  end

endmodule

// ----- sv/lmsd_outq.sv -----
// two-entry output skid queue for result transactions
`timescale 1ns / 1ps
module lmsd_outq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lmsd_pkg::pins_t push_data,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output lmsd_pkg::pins_t head
);

  lmsd_pkg::pins_t q0;
  lmsd_pkg::pins_t q1;
  logic [1:0]      count;
  logic            pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign head      = q0;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // entry data
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd2) begin
        q0 <= q1;
        q1 <= push_data;
      end else begin
        q0 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        q0 <= push_data;
      end else begin
        q1 <= push_data;
      end
    end else if (pop) begin
      q0 <= q1;
    end
  end

endmodule

// ----- sv/lcd_multiplex_scan_driver.sv -----
// top level of the quarter-duty multiplexed lcd scan driver
`timescale 1ns / 1ps
// Drives a 4-common, 12-segment multiplexed LCD at quarter duty and half bias.
// Input channel (in_valid / in_stall): mode selects a frame word update, a
// blanking tick or a scan tick; row, set_bits and clear_bits serve updates.
// Output channel (out_valid / out_stall): every input transaction yields one
// result with the segment levels, common levels and common drive enables as
// they stand after that transaction (updates repeat the current levels).
// Each accepted input writes its result into the output queue. Throughput: one
// transaction per cycle while the queue is not full, set by the single state
// update in the core and the pop rate of the output queue.
// When the receiver stalls, up to two results wait in the output queue and
// input keeps being accepted until both entries are taken; in_stall then
// rises and comes from a register only.
// Reset clears the frame store, the scan position and phase, all pin levels
// and enables, and empties the output queue.
module lcd_multiplex_scan_driver (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lmsd_pkg::MODE_W-1:0] mode,
  input  lmsd_pkg::row_t              row,
  input  lmsd_pkg::seg_word_t         set_bits,
  input  lmsd_pkg::seg_word_t         clear_bits,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lmsd_pkg::seg_word_t         segment_lines,
  output lmsd_pkg::com_word_t         common_level,
  output lmsd_pkg::com_word_t         common_enable
);

  logic            accept;
  lmsd_pkg::pins_t pins_next;
  lmsd_pkg::pins_t head;

  assign accept = in_valid && !in_stall;

  lmsd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .mode       (mode),
    .row        (row),
    .set_bits   (set_bits),
    .clear_bits (clear_bits),
    .pins_next  (pins_next)
  );

  lmsd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (pins_next),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign segment_lines = head.seg;
  assign common_level  = head.com_level;
  assign common_enable = head.com_enable;

  // a full queue always has a result on offer
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // an accepted transaction leaves a result on the output
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  // the queue only fills while the receiver holds it off
  a_fill_needs_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> ($past(accept) && $past(out_stall)))
    else $error("queue filled without a stalled receiver");

endmodule
